FILE: rtl/core/atsd_pkg.sv
`timescale 1ns / 1ps

package atsd_pkg;

    localparam int ANGLE_ITERATIONS_DEF = 16;
    localparam int ANGLE_ITER_MAX       = 24;
    localparam int ITER_IDX_W           = $clog2(ANGLE_ITER_MAX);

    localparam int RAW_W    = 16;
    localparam int FILT_W   = 24;
    localparam int SQ_W     = 48;
    localparam int ROOT_W   = 24;
    localparam int OPND_W   = 25;
    localparam int CORDIC_W = 28;
    localparam int ACC_W    = 26;
    localparam int ANG_W    = ACC_W - 8;
    localparam int ATAN_W   = 22;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [16:0] COEF_RST    = 17'd13107;
    localparam logic [16:0] COEF_MAX    = 17'd65536;
    localparam logic [14:0] SHK_THR_RST = 15'd6144;
    localparam logic [15:0] SHK_INT_RST = 16'd600;
    localparam logic [14:0] TLT_THR_RST = 15'd6400;
    localparam logic [15:0] TLT_INT_RST = 16'd800;

    // 180 degrees in 1/65536 degree
    localparam logic signed [ACC_W-1:0] HALF_TURN = 26'sd11796480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF    = 3'd0,
        CFG_SHK_THR = 3'd1,
        CFG_SHK_INT = 3'd2,
        CFG_TLT_THR = 3'd3,
        CFG_TLT_INT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic              start;
        logic [SQ_W-1:0]   radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sqrt_stat;

    typedef struct packed {
        logic                     start;
        logic signed [OPND_W-1:0] y;
        logic signed [OPND_W-1:0] x;
    } t_cordic_req;

    typedef struct packed {
        logic                    done;
        logic signed [ANG_W-1:0] angle;
    } t_cordic_stat;

    // arctangent of 2^-i in 1/65536 degree
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [ITER_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/atsd_in_if.sv
`timescale 1ns / 1ps

interface atsd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        now_ms;

    modport source(output valid, output accel_x, output accel_y, output accel_z,
                   output now_ms, input ready);
    modport sink(input valid, input accel_x, input accel_y, input accel_z,
                 input now_ms, output ready);
endinterface

FILE: rtl/core/atsd_out_if.sv
`timescale 1ns / 1ps

interface atsd_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic               shake_event;
    logic [15:0]        shake_strength;
    logic               tilt_event;
    logic [15:0]        tilt_strength;
    logic               tilted_flag;

    modport source(output valid, output roll_angle, output pitch_angle,
                   output shake_event, output shake_strength, output tilt_event,
                   output tilt_strength, output tilted_flag, input ready);
    modport sink(input valid, input roll_angle, input pitch_angle,
                 input shake_event, input shake_strength, input tilt_event,
                 input tilt_strength, input tilted_flag, output ready);
endinterface

FILE: rtl/core/atsd_isqrt.sv
`timescale 1ns / 1ps

module atsd_isqrt (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  atsd_pkg::t_sqrt_req    i_req,
    output atsd_pkg::t_sqrt_stat   o_stat
);
    localparam int SQ_W   = atsd_pkg::SQ_W;
    localparam int ROOT_W = atsd_pkg::ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ROOT_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [SQ_W-1:0]   r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              fits;
    logic [REM_W+1:0]  rem_sub;

    // one root bit per cycle, two radicand bits shifted in
    always_comb begin
        rem_sh  = {r_rem, r_rad[SQ_W-1 -: 2]};
        trial   = {2'b00, r_root, 2'b01};
        fits    = (rem_sh >= trial);
        rem_sub = rem_sh - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rad  <= i_req.radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[SQ_W-3:0], 2'b00};
            if (fits) begin
                r_rem  <= rem_sub[REM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[REM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.root = r_root;

endmodule

FILE: rtl/core/atsd_cordic.sv
`timescale 1ns / 1ps

module atsd_cordic #(
    parameter int ANGLE_ITERATIONS = atsd_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  atsd_pkg::t_cordic_req  i_req,
    output atsd_pkg::t_cordic_stat o_stat
);
    localparam int CW     = atsd_pkg::CORDIC_W;
    localparam int ACC_W  = atsd_pkg::ACC_W;
    localparam int ANG_W  = atsd_pkg::ANG_W;
    localparam int ATAN_W = atsd_pkg::ATAN_W;
    localparam int CNT_W  = atsd_pkg::ITER_IDX_W;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ANGLE_ITERATIONS - 1);

    logic                    r_busy;
    logic                    r_done;
    logic                    r_zero;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [CW-1:0]    r_x;
    logic signed [CW-1:0]    r_y;
    logic signed [ACC_W-1:0] r_acc;

    logic signed [CW-1:0]    in_x;
    logic signed [CW-1:0]    in_y;
    logic signed [CW-1:0]    xs;
    logic signed [CW-1:0]    ys;
    logic signed [ACC_W-1:0] step;
    logic signed [ACC_W-1:0] acc_rnd;

    always_comb begin
        in_x    = CW'(i_req.x);
        in_y    = CW'(i_req.y);
        xs      = r_x >>> r_cnt;
        ys      = r_y >>> r_cnt;
        step    = $signed({{(ACC_W - ATAN_W){1'b0}}, atsd_pkg::atan_entry(r_cnt)});
        acc_rnd = r_acc + ACC_W'(128);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_zero <= (i_req.x == '0) && (i_req.y == '0);
            // fold the left half plane onto the right
            if (i_req.x < 0) begin
                r_x   <= -in_x;
                r_y   <= -in_y;
                r_acc <= (i_req.y >= 0) ? atsd_pkg::HALF_TURN : -atsd_pkg::HALF_TURN;
            end else begin
                r_x   <= in_x;
                r_y   <= in_y;
                r_acc <= '0;
            end
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x   <= r_x + ys;
                r_y   <= r_y - xs;
                r_acc <= r_acc + step;
            end else begin
                r_x   <= r_x - ys;
                r_y   <= r_y + xs;
                r_acc <= r_acc - step;
            end
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.angle = r_zero ? '0 : acc_rnd[ACC_W-1 -: ANG_W];

endmodule

FILE: rtl/core/accel_tilt_shake_detector.sv
`timescale 1ns / 1ps

// Tilt and shake detector for a three-axis accelerometer. One sample request
// (Q4.12 g per axis plus a millisecond timestamp) gives one result request
// with roll, pitch, shake and tilt events and the tilt state. Samples are
// handled one at a time: three axis filter steps and three squares, then
// three root extractions on the single bit-serial square root unit, which
// set the pace, with the CORDIC for roll and pitch running beside them and
// the tilt CORDIC after the last root. A new sample is taken while the
// previous result still waits at the output. Configuration is written
// through a plain write port; the user must write it only while the block
// is idle, and the block itself does not enforce this.
module accel_tilt_shake_detector #(
    parameter int ANGLE_ITERATIONS = atsd_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [atsd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [atsd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    atsd_in_if.sink                          i_sample,
    atsd_out_if.source                       o_result
);
    localparam int FILT_W = atsd_pkg::FILT_W;
    localparam int SQ_W   = atsd_pkg::SQ_W;
    localparam int ROOT_W = atsd_pkg::ROOT_W;
    localparam int OPND_W = atsd_pkg::OPND_W;
    localparam int ANG_W  = atsd_pkg::ANG_W;

    localparam logic signed [ANG_W-1:0] ROLL_LIM  = 18'sd46080;
    localparam logic signed [ANG_W-1:0] PITCH_LIM = 18'sd23040;
    localparam logic signed [ANG_W-1:0] TILT_LIM  = 18'sd23040;
    localparam logic [SQ_W-1:0]         SMALL_SUMSQ = 48'd43980465112;
    localparam int                      RECIP_SHIFT = 27;
    localparam logic [22:0]             RECIP_30    = 23'd4473924;
    localparam logic [21:0]             DIV_30      = 22'd30;

    typedef enum logic [3:0] {
        S_IDLE, S_FILT, S_SQ, S_L_ROLL, S_W_ROLL, S_L_PITCH, S_W_PITCH,
        S_L_TSQ, S_W_TSQ, S_L_TCOR, S_W_TCOR, S_EVT, S_FIX, S_OUT
    } t_state;

    function automatic logic signed [ANG_W-1:0] clamp_sym(
        input logic signed [ANG_W-1:0] v, input logic signed [ANG_W-1:0] lim);
        logic signed [ANG_W-1:0] r;
        if (v < -lim)     r = -lim;
        else if (v > lim) r = lim;
        else              r = v;
        return r;
    endfunction

    t_state r_state;
    logic [1:0] r_axis;
    logic       r_ovalid;

    logic [16:0] r_coef;
    logic [14:0] r_shk_thr;
    logic [15:0] r_shk_int;
    logic [14:0] r_tlt_thr;
    logic [15:0] r_tlt_int;

    logic signed [FILT_W-1:0] r_fx, r_fy, r_fz;
    logic [31:0] r_last_shk, r_last_tlt;
    logic        r_tilted;

    // datapath, no reset
    logic signed [15:0] r_ax, r_ay, r_az;
    logic [31:0]        r_now;
    logic [SQ_W-2:0]    r_xx, r_yy, r_zz;
    logic [SQ_W-1:0]    r_sumsq;
    logic [ROOT_W-1:0]  r_root_yz;
    logic [ROOT_W-1:0]  r_mag;
    logic signed [16:0] r_roll;
    logic signed [15:0] r_pitch;
    logic [14:0]        r_tilt;
    logic               r_sev;
    logic [15:0]        r_sstr;
    logic               r_tev;
    logic [16:0]        r_q0;
    logic [15:0]        r_tstr;

    atsd_pkg::t_sqrt_req    sq_req;
    atsd_pkg::t_sqrt_stat   sq_stat;
    atsd_pkg::t_cordic_req  co_req;
    atsd_pkg::t_cordic_stat co_stat;

    // filter
    logic signed [FILT_W-1:0] f_sel;
    logic signed [15:0]       raw_sel;
    logic signed [FILT_W-1:0] raw_w;
    logic signed [24:0]       diff;
    logic signed [42:0]       prod;
    logic [41:0]              prod_mag;
    logic [25:0]              d_mag;
    logic signed [26:0]       d_s;
    logic signed [26:0]       f_sum;
    logic signed [FILT_W-1:0] f_new;
    logic signed [SQ_W-1:0]   sq_full;

    // events
    logic               shk_fire;
    logic [22:0]        shk_lvl;
    logic [24:0]        shk_ex;
    logic [20:0]        shk_q;
    logic               tlt_fire;
    logic               tlt_rel;
    logic [17:0]        tlt_5;
    logic [17:0]        thr_3;
    logic [21:0]        tdiv_n;
    logic [44:0]        tdiv_p;
    logic [21:0]        tdiv_r;
    logic [16:0]        tdiv_q;
    logic [ROOT_W-1:0]  abs_z;
    logic               out_load;
    logic               both_done;

    always_comb begin
        unique case (r_axis)
            2'd0:    begin f_sel = r_fx; raw_sel = r_ax; end
            2'd1:    begin f_sel = r_fy; raw_sel = r_ay; end
            2'd2:    begin f_sel = r_fz; raw_sel = r_az; end
            default: begin f_sel = r_fz; raw_sel = r_az; end
        endcase
        raw_w    = $signed({raw_sel, 8'h00});
        diff     = 25'(raw_w) - 25'(f_sel);
        prod     = 43'(diff) * 43'($signed({1'b0, r_coef}));
        prod_mag = prod[42] ? 42'(-prod) : prod[41:0];
        d_mag    = 26'((prod_mag + 42'd32768) >> 16);
        d_s      = prod[42] ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});
        f_sum    = 27'(f_sel) + d_s;
        f_new    = f_sum[FILT_W-1:0];
        sq_full  = SQ_W'(f_sel) * SQ_W'(f_sel);
    end

    always_comb begin
        abs_z = r_fz[FILT_W-1] ? ROOT_W'(-r_fz) : ROOT_W'(r_fz);

        sq_req.start = (r_state == S_L_ROLL) || (r_state == S_L_PITCH)
                    || (r_state == S_L_TSQ);
        priority if (r_state == S_L_ROLL)
            sq_req.radicand = SQ_W'(r_yy) + SQ_W'(r_zz);
        else if (r_state == S_L_PITCH)
            sq_req.radicand = SQ_W'(r_xx) + SQ_W'(r_yy) + SQ_W'(r_zz);
        else
            sq_req.radicand = SQ_W'(r_xx) + SQ_W'(r_yy);

        co_req.start = (r_state == S_L_ROLL) || (r_state == S_L_PITCH)
                    || (r_state == S_L_TCOR);
        priority if (r_state == S_L_ROLL) begin
            co_req.y = OPND_W'(r_fy);
            co_req.x = OPND_W'(r_fz);
        end else if (r_state == S_L_PITCH) begin
            co_req.y = -OPND_W'(r_fx);
            co_req.x = $signed({1'b0, r_root_yz});
        end else begin
            co_req.y = $signed({1'b0, sq_stat.root});
            co_req.x = $signed({1'b0, abs_z});
        end

        both_done = sq_stat.done && co_stat.done;
    end

    always_comb begin
        shk_lvl  = {r_shk_thr, 8'h00};
        shk_fire = (r_mag >= ROOT_W'(shk_lvl))
                && ((r_now - r_last_shk) >= 32'(r_shk_int));
        shk_ex   = 25'(r_mag) - 25'(shk_lvl) + 25'd8;
        shk_q    = shk_ex[24:4];

        tlt_fire = !r_tilted && (r_tilt >= r_tlt_thr)
                && ((r_now - r_last_tlt) >= 32'(r_tlt_int));
        tlt_5    = 18'(r_tilt) * 18'd5;
        thr_3    = 18'(r_tlt_thr) * 18'd3;
        tlt_rel  = r_tilted && (tlt_5 <= thr_3);

        // divide by 30 through a reciprocal, then one correction step
        tdiv_n = {r_tilt, 7'h00} + 22'd15;
        tdiv_p = 45'(tdiv_n) * 45'(RECIP_30);
        tdiv_r = tdiv_n - 22'(r_q0) * 22'd30;
        tdiv_q = r_q0 + ((tdiv_r >= DIV_30) ? 17'd1 : 17'd0);

        out_load = (r_state == S_OUT) && (!r_ovalid || o_result.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_axis     <= '0;
            r_ovalid   <= 1'b0;
            r_coef     <= atsd_pkg::COEF_RST;
            r_shk_thr  <= atsd_pkg::SHK_THR_RST;
            r_shk_int  <= atsd_pkg::SHK_INT_RST;
            r_tlt_thr  <= atsd_pkg::TLT_THR_RST;
            r_tlt_int  <= atsd_pkg::TLT_INT_RST;
            r_fx       <= '0;
            r_fy       <= '0;
            r_fz       <= '0;
            r_last_shk <= '0;
            r_last_tlt <= '0;
            r_tilted   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    atsd_pkg::CFG_COEF:
                        r_coef <= (i_cfg_data > atsd_pkg::COEF_MAX) ? atsd_pkg::COEF_MAX
                                                                    : i_cfg_data;
                    atsd_pkg::CFG_SHK_THR: r_shk_thr <= i_cfg_data[14:0];
                    atsd_pkg::CFG_SHK_INT: r_shk_int <= i_cfg_data[15:0];
                    atsd_pkg::CFG_TLT_THR: r_tlt_thr <= i_cfg_data[14:0];
                    atsd_pkg::CFG_TLT_INT: r_tlt_int <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            if (r_ovalid && o_result.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_sample.valid) begin
                        r_state <= S_FILT;
                        r_axis  <= '0;
                    end
                end
                S_FILT: begin
                    unique case (r_axis)
                        2'd0:    r_fx <= f_new;
                        2'd1:    r_fy <= f_new;
                        default: r_fz <= f_new;
                    endcase
                    if (r_axis == 2'd2) begin
                        r_axis  <= '0;
                        r_state <= S_SQ;
                    end else begin
                        r_axis <= r_axis + 1'b1;
                    end
                end
                S_SQ: begin
                    if (r_axis == 2'd2) begin
                        r_axis  <= '0;
                        r_state <= S_L_ROLL;
                    end else begin
                        r_axis <= r_axis + 1'b1;
                    end
                end
                S_L_ROLL:  r_state <= S_W_ROLL;
                S_W_ROLL:  if (both_done) r_state <= S_L_PITCH;
                S_L_PITCH: r_state <= S_W_PITCH;
                S_W_PITCH: if (both_done) r_state <= S_L_TSQ;
                S_L_TSQ:   r_state <= S_W_TSQ;
                S_W_TSQ: begin
                    if (sq_stat.done) begin
                        r_state <= (r_sumsq >= SMALL_SUMSQ) ? S_L_TCOR : S_EVT;
                    end
                end
                S_L_TCOR:  r_state <= S_W_TCOR;
                S_W_TCOR:  if (co_stat.done) r_state <= S_EVT;
                S_EVT: begin
                    if (shk_fire) begin
                        r_last_shk <= r_now;
                    end
                    if (tlt_fire) begin
                        r_last_tlt <= r_now;
                        r_tilted   <= 1'b1;
                    end else if (tlt_rel) begin
                        r_tilted <= 1'b0;
                    end
                    r_state <= S_FIX;
                end
                S_FIX: r_state <= S_OUT;
                S_OUT: begin
                    if (out_load) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_sample.valid) begin
            r_ax  <= i_sample.accel_x;
            r_ay  <= i_sample.accel_y;
            r_az  <= i_sample.accel_z;
            r_now <= i_sample.now_ms;
        end
        if (r_state == S_SQ) begin
            unique case (r_axis)
                2'd0:    r_xx <= sq_full[SQ_W-2:0];
                2'd1:    r_yy <= sq_full[SQ_W-2:0];
                default: r_zz <= sq_full[SQ_W-2:0];
            endcase
        end
        if (r_state == S_L_PITCH) begin
            r_sumsq <= sq_req.radicand;
        end
        if (r_state == S_W_ROLL && both_done) begin
            r_roll    <= 17'(clamp_sym(co_stat.angle, ROLL_LIM));
            r_root_yz <= sq_stat.root;
        end
        if (r_state == S_W_PITCH && both_done) begin
            r_pitch <= 16'(clamp_sym(co_stat.angle, PITCH_LIM));
            r_mag   <= sq_stat.root;
        end
        if (r_state == S_W_TSQ && sq_stat.done && r_sumsq < SMALL_SUMSQ) begin
            r_tilt <= '0;
        end
        if (r_state == S_W_TCOR && co_stat.done) begin
            priority if (co_stat.angle < 0)
                r_tilt <= '0;
            else if (co_stat.angle > TILT_LIM)
                r_tilt <= 15'(TILT_LIM);
            else
                r_tilt <= 15'(co_stat.angle);
        end
        if (r_state == S_EVT) begin
            r_sev  <= shk_fire;
            r_sstr <= !shk_fire ? '0 : ((shk_q > 21'd65535) ? 16'hFFFF : shk_q[15:0]);
            r_tev  <= tlt_fire;
            r_q0   <= tdiv_p[RECIP_SHIFT +: 17];
        end
        if (r_state == S_FIX) begin
            r_tstr <= !r_tev ? '0 : ((tdiv_q > 17'd65535) ? 16'hFFFF : tdiv_q[15:0]);
        end
        if (out_load) begin
            o_result.roll_angle     <= r_roll;
            o_result.pitch_angle    <= r_pitch;
            o_result.shake_event    <= r_sev;
            o_result.shake_strength <= r_sstr;
            o_result.tilt_event     <= r_tev;
            o_result.tilt_strength  <= r_tstr;
            o_result.tilted_flag    <= r_tilted;
        end
    end

    assign i_sample.ready = (r_state == S_IDLE);
    assign o_result.valid = r_ovalid;

    atsd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_stat  (sq_stat)
    );

    atsd_cordic #(
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (co_req),
        .o_stat  (co_stat)
    );

`ifndef SYNTHESIS
    a_tilt_evt_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (!o_result.tilt_event || o_result.tilted_flag))
        else $error("tilt event without tilted state");

    a_shake_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.shake_event) |-> (o_result.shake_strength == '0))
        else $error("shake strength without shake event");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> !i_sample.ready)
        else $error("second sample taken while busy");

    a_root_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_req.start |=> !sq_stat.done)
        else $error("square root done too early");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int  SETTLE_CYCLES = 200;
    localparam int  CYCLE_LIMIT   = 1500000;
    localparam int  HOLD_CYCLES   = 800;
    localparam longint SMALL_SUMSQ = 64'd43980465112;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [31:0]        now_ms;
    } t_sample;

    typedef struct {
        logic signed [16:0] roll;
        logic signed [15:0] pitch;
        logic               shk_ev;
        logic [15:0]        shk_str;
        logic               tlt_ev;
        logic [15:0]        tlt_str;
        logic               tilted;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [atsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [atsd_pkg::CFG_DATA_W-1:0] i_cfg_data;

    atsd_in_if  smp();
    atsd_out_if res();

    accel_tilt_shake_detector dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (smp),
        .o_result   (res)
    );

    t_sample pending_samples[$];
    t_result expected_results[$];

    int errors;
    int cycles;
    int n_samples;
    int n_results;
    int n_shakes;
    int n_tilts;
    int idle_pct;
    int hold_cnt;
    bit hold_req;
    bit sample_taken;
    logic [31:0] clock_ms;

    // predictor copy of registers and state
    logic [16:0] m_coef;
    logic [14:0] m_shk_thr;
    logic [15:0] m_shk_int;
    logic [14:0] m_tlt_thr;
    logic [15:0] m_tlt_int;
    longint      m_fx, m_fy, m_fz;
    logic [31:0] m_last_shake;
    logic [31:0] m_last_tilt;
    logic        m_tilted;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic longint filter_step(longint f, longint raw);
        longint p, m, d;
        p = (raw * 256 - f) * longint'(m_coef);
        m = (p < 0) ? -p : p;
        d = (m + 32768) >>> 16;
        return (p < 0) ? f - d : f + d;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // vectoring CORDIC, result in 1/256 degree
    function automatic longint cordic_angle(longint y, longint x);
        longint acc, xs, ys;
        int n;
        acc = 0;
        n = (atsd_pkg::ANGLE_ITERATIONS_DEF > atsd_pkg::ANGLE_ITER_MAX)
            ? atsd_pkg::ANGLE_ITER_MAX : atsd_pkg::ANGLE_ITERATIONS_DEF;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            acc = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < n; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs;
                acc = acc + longint'(atsd_pkg::atan_entry(atsd_pkg::ITER_IDX_W'(i)));
            end else begin
                x = x - ys; y = y + xs;
                acc = acc - longint'(atsd_pkg::atan_entry(atsd_pkg::ITER_IDX_W'(i)));
            end
        end
        return (acc + 128) >>> 8;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic t_result predict_detection(t_sample s);
        t_result r;
        longint x, y, z, xx, yy, zz, mag, thr, tilt, sstr, tstr;
        logic [31:0] elapsed;
        m_fx = filter_step(m_fx, longint'(s.ax));
        m_fy = filter_step(m_fy, longint'(s.ay));
        m_fz = filter_step(m_fz, longint'(s.az));
        x = m_fx; y = m_fy; z = m_fz;
        xx = x * x; yy = y * y; zz = z * z;
        r.roll  = 17'(clamp(cordic_angle(y, z), -46080, 46080));
        r.pitch = 16'(clamp(cordic_angle(-x, int_sqrt(yy + zz)), -23040, 23040));
        mag = int_sqrt(xx + yy + zz);
        r.shk_ev = 1'b0; r.shk_str = '0;
        r.tlt_ev = 1'b0; r.tlt_str = '0;
        thr = longint'(m_shk_thr) << 8;
        elapsed = s.now_ms - m_last_shake;
        if (mag >= thr && elapsed >= {16'd0, m_shk_int}) begin
            m_last_shake = s.now_ms;
            r.shk_ev = 1'b1;
            sstr = (mag - thr + 8) >>> 4;
            r.shk_str = (sstr > 65535) ? 16'hFFFF : sstr[15:0];
        end
        tilt = 0;
        if (xx + yy + zz >= SMALL_SUMSQ)
            tilt = clamp(cordic_angle(int_sqrt(xx + yy), (z < 0) ? -z : z), 0, 23040);
        elapsed = s.now_ms - m_last_tilt;
        if (!m_tilted && tilt >= longint'(m_tlt_thr)) begin
            if (elapsed >= {16'd0, m_tlt_int}) begin
                m_last_tilt = s.now_ms;
                m_tilted = 1'b1;
                r.tlt_ev = 1'b1;
                tstr = (tilt * 128 + 15) / 30;
                r.tlt_str = (tstr > 65535) ? 16'hFFFF : tstr[15:0];
            end
        end else if (m_tilted && tilt * 5 <= longint'(m_tlt_thr) * 3) begin
            m_tilted = 1'b0;
        end
        r.tilted = m_tilted;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] result %0d: %s got %0d expected %0d", $realtime, n_results, what,
                 got, want);
        errors++;
    endtask

    // sample side: take the request, predict, advance; result side: check each result
    always @(posedge i_clk) begin
        t_result e;
        t_sample s;
        sample_taken = 1'b0;
        if (i_rst_n && smp.valid && smp.ready) begin
            s.ax = smp.accel_x; s.ay = smp.accel_y; s.az = smp.accel_z;
            s.now_ms = smp.now_ms;
            expected_results.push_back(predict_detection(s));
            void'(pending_samples.pop_front());
            sample_taken = 1'b1;
            n_samples++;
        end
        if (i_rst_n && res.valid && res.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with no sample pending", 1, 0);
            end else begin
                e = expected_results.pop_front();
                if (res.roll_angle !== e.roll) report_mismatch("roll", res.roll_angle, e.roll);
                if (res.pitch_angle !== e.pitch)
                    report_mismatch("pitch", res.pitch_angle, e.pitch);
                if (res.shake_event !== e.shk_ev)
                    report_mismatch("shake_event", res.shake_event, e.shk_ev);
                if (res.shake_strength !== e.shk_str)
                    report_mismatch("shake_strength", res.shake_strength, e.shk_str);
                if (res.tilt_event !== e.tlt_ev)
                    report_mismatch("tilt_event", res.tilt_event, e.tlt_ev);
                if (res.tilt_strength !== e.tlt_str)
                    report_mismatch("tilt_strength", res.tilt_strength, e.tlt_str);
                if (res.tilted_flag !== e.tilted)
                    report_mismatch("tilted_flag", res.tilted_flag, e.tilted);
                n_shakes += e.shk_ev;
                n_tilts  += e.tlt_ev;
            end
            n_results++;
        end
    end

    // sample driver: hold an unaccepted request, otherwise offer the next one
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            smp.valid <= 1'b0;
        end else if (smp.valid && !sample_taken) begin
            smp.valid <= 1'b1;
        end else if (pending_samples.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
            smp.valid   <= 1'b1;
            smp.accel_x <= pending_samples[0].ax;
            smp.accel_y <= pending_samples[0].ay;
            smp.accel_z <= pending_samples[0].az;
            smp.now_ms  <= pending_samples[0].now_ms;
        end else begin
            smp.valid <= 1'b0;
        end
    end

    // result receiver, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_cnt = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0) begin
            res.ready <= 1'b0;
            hold_cnt--;
        end else begin
            res.ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    task automatic write_reg(logic [atsd_pkg::CFG_IDX_W-1:0] idx,
                             logic [atsd_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            atsd_pkg::CFG_COEF:
                m_coef = (val > atsd_pkg::COEF_MAX) ? atsd_pkg::COEF_MAX : val;
            atsd_pkg::CFG_SHK_THR: m_shk_thr = val[14:0];
            atsd_pkg::CFG_SHK_INT: m_shk_int = val[15:0];
            atsd_pkg::CFG_TLT_THR: m_tlt_thr = val[14:0];
            atsd_pkg::CFG_TLT_INT: m_tlt_int = val[15:0];
            default: ;
        endcase
    endtask

    task automatic write_all(int coef, int shk_thr, int shk_int, int tlt_thr, int tlt_int);
        write_reg(atsd_pkg::CFG_COEF, atsd_pkg::CFG_DATA_W'(coef));
        write_reg(atsd_pkg::CFG_SHK_THR, atsd_pkg::CFG_DATA_W'(shk_thr));
        write_reg(atsd_pkg::CFG_SHK_INT, atsd_pkg::CFG_DATA_W'(shk_int));
        write_reg(atsd_pkg::CFG_TLT_THR, atsd_pkg::CFG_DATA_W'(tlt_thr));
        write_reg(atsd_pkg::CFG_TLT_INT, atsd_pkg::CFG_DATA_W'(tlt_int));
        // unused index, must be dropped
        write_reg(atsd_pkg::CFG_IDX_W'($urandom_range(5, 7)),
                  atsd_pkg::CFG_DATA_W'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_sample(int x, int y, int z, int dt);
        t_sample s;
        clock_ms += 32'(dt);
        s.ax = 16'(x); s.ay = 16'(y); s.az = 16'(z); s.now_ms = clock_ms;
        pending_samples.push_back(s);
    endtask

    task automatic push_random_sample();
        int r;
        t_sample s;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
        else clock_ms += $urandom_range(0, 500);
        s.now_ms = clock_ms;
        if (r < 15) begin
            s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
        end else if (r < 50) begin
            s.ax = 16'($urandom_range(0, 4096) - 2048);
            s.ay = 16'($urandom_range(0, 4096) - 2048);
            s.az = 16'(($urandom_range(0, 1) ? 4096 : -4096) + $urandom_range(0, 800) - 400);
        end else if (r < 85) begin
            // choose at random between lying flat and standing on edge
            if ($urandom_range(0, 1)) begin
                s.ax = 16'($urandom_range(0, 400) - 200);
                s.ay = 16'($urandom_range(0, 400) - 200);
                s.az = 16'(($urandom_range(0, 1) ? 4096 : -4096));
            end else begin
                s.ax = 16'(($urandom_range(0, 1) ? 4096 : -4096));
                s.ay = 16'($urandom_range(0, 3000) - 1500);
                s.az = 16'($urandom_range(0, 3000) - 1500);
            end
        end else begin
            s.ax = 16'($urandom_range(0, 65535) - 32768);
            s.ay = 16'($urandom_range(0, 16384) - 8192);
            s.az = 16'($urandom_range(0, 1) ? $urandom_range(8192, 32767)
                                            : -$urandom_range(8192, 32768));
        end
        pending_samples.push_back(s);
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0 && expected_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        errors = 0; cycles = 0; n_samples = 0; n_results = 0;
        n_shakes = 0; n_tilts = 0; hold_cnt = 0; hold_req = 1'b0;
        idle_pct = 38; sample_taken = 1'b0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        smp.valid = 1'b0; smp.accel_x = '0; smp.accel_y = '0; smp.accel_z = '0;
        smp.now_ms = '0; res.ready = 1'b0;
        m_coef = atsd_pkg::COEF_RST; m_shk_thr = atsd_pkg::SHK_THR_RST;
        m_shk_int = atsd_pkg::SHK_INT_RST;
        m_tlt_thr = atsd_pkg::TLT_THR_RST; m_tlt_int = atsd_pkg::TLT_INT_RST;
        m_fx = 0; m_fy = 0; m_fz = 0;
        m_last_shake = '0; m_last_tilt = '0; m_tilted = 1'b0;
        clock_ms = 32'd0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // a few samples under reset values
        push_sample(0, 0, 4096, 10);
        push_sample(4096, 0, 0, 900);
        push_sample(32767, -32768, 32767, 700);
        drain();

        // directed: unfiltered samples, timestamps crossing the wrap
        write_all(atsd_pkg::COEF_MAX, 6144, 600, 6400, 800);
        clock_ms = 32'hFFFF_FC00;
        push_sample(0, 0, 0, 0);
        push_sample(0, 0, 100, 5);
        push_sample(0, 0, 4096, 5);
        push_sample(0, 0, -4096, 5);
        push_sample(4096, 0, 0, 900);
        push_sample(0, 0, 4096, 5);
        push_sample(4096, 0, 0, 5);
        push_sample(0, 4096, 100, 900);
        push_sample(32767, 32767, 32767, 10);
        push_sample(-32768, -32768, -32768, 10);
        push_sample(-32768, -32768, -32768, 700);
        push_sample(-32768, 0, 0, 5);
        push_sample(0, -32768, 0, 900);
        push_sample(0, 0, -32768, 5);
        push_sample(32767, -32768, 0, 700);
        push_sample(0, 0, 4096, 5);
        push_sample(-4096, 0, 0, 1000);
        push_sample(0, -4096, -100, 900);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: write_all(131071, 0, 0, 0, 0);
                1: write_all(atsd_pkg::COEF_MAX, 32767, 65535, 23040, 65535);
                2: write_all(0, 6144, 600, 6400, 800);
                3: write_all(40000, 5000, 200, 32767, 100);
                4: write_all(atsd_pkg::COEF_MAX, $urandom_range(4096, 9000),
                             $urandom_range(0, 800), $urandom_range(3000, 12000),
                             $urandom_range(0, 900));
                default: write_all($urandom_range(1, 131071), $urandom_range(0, 32767),
                                   $urandom_range(0, 65535), $urandom_range(0, 32767),
                                   $urandom_range(0, 65535));
            endcase
            idle_pct = (ph == 2) ? 0 : 38;
            if (ph == 1) hold_req = 1'b1;
            repeat ((ph == 2) ? 100 : 290) push_random_sample();
            drain();
        end

        $display("samples %0d, results %0d, shake events %0d, tilt events %0d",
                 n_samples, n_results, n_shakes, n_tilts);
        $display("covered register extremes, wrapped timestamps and a long output stall");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
